// File: rtl/core/slm_pkg.sv
// Shared types and constants for the sorted list merge block.
// No dependencies; imported by the interfaces and every module.
package slm_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CMD_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND_A = 2'd0,
    CMD_APPEND_B = 2'd1,
    CMD_MERGE    = 2'd2
  } cmd_e;

endpackage

// File: rtl/core/slm_if.sv
// Valid/ready channel interfaces for the command input and the merged output.
// Depends on slm_pkg for the field widths.
interface slm_in_if
  import slm_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

interface slm_out_if
  import slm_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] merged_value;
  logic                     last_item;
  logic                     dropped;

  modport source (output valid, merged_value, last_item, dropped, input ready);
  modport sink   (input valid, merged_value, last_item, dropped, output ready);
endinterface

// File: rtl/core/slm_list_mem.sv
// Single list store: one write port, one read port, registered read data.
// Depends on slm_pkg for the data width.
module slm_list_mem
  import slm_pkg::*;
#(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/core/sorted_list_merge.sv
// Channel  Dir  Payload                              Beat when
// in_i     in   command[1:0], value[31:0] signed     in_i.valid & in_i.ready
// out_o    out  merged_value[31:0], last_item, dropped out_o.valid & out_o.ready
//
// Appends write the tail of list A or list B; an append to a full list sets dropped.
// A merge reads both list heads at its accepting edge, then emits one at a time,
// paced by the output register; input is held off until the last element
// is loaded into the output register. A merge of two empty lists only clears dropped.
// Both stores read one entry a cycle; the merge takes one element per unstalled cycle.
// rst_ni clears the counts, the dropped flag and the output valid; the stores are
// not cleared. An output stall freezes the merge with both heads held.
// Top level of the sorted list merge; uses slm_pkg, slm_if and slm_list_mem.
module sorted_list_merge
  import slm_pkg::*;
#(
  parameter int unsigned MAX_LEN = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  slm_in_if.sink    in_i,
  slm_out_if.source out_o
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam int unsigned SW = CW + 1;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CW-1:0]     idx_a_q, idx_a_d, idx_b_q, idx_b_d;
  logic              drop_q, drop_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_value_q, out_value_d;
  logic              out_last_q, out_last_d;
  logic              out_drop_q, out_drop_d;

  logic              in_fire, slot_free, take_a, is_last, emit;
  logic              wr_a, wr_b;
  logic [DATA_W-1:0] head_a, head_b;
  logic [SW-1:0]     total, consumed;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign slot_free  = !out_valid_q || out_o.ready;
  assign total      = {1'b0, cnt_a_q} + {1'b0, cnt_b_q};
  assign consumed   = {1'b0, idx_a_q} + {1'b0, idx_b_q} + SW'(1);
  assign is_last    = (consumed == total);
  assign emit       = (state_q == ST_MERGE) && slot_free;

  // A goes first when strictly smaller or when B is used up; ties go to B.
  assign take_a = (idx_a_q < cnt_a_q) &&
                  ((idx_b_q >= cnt_b_q) || ($signed(head_a) < $signed(head_b)));

  always_comb begin
    state_d     = state_q;
    cnt_a_d     = cnt_a_q;
    cnt_b_d     = cnt_b_q;
    idx_a_d     = idx_a_q;
    idx_b_d     = idx_b_q;
    drop_d      = drop_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    out_drop_d  = out_drop_q;
    wr_a        = 1'b0;
    wr_b        = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        idx_a_d = '0;
        idx_b_d = '0;
        if (in_fire) begin
          unique case (in_i.command)
            CMD_APPEND_A: begin
              if (cnt_a_q < CW'(MAX_LEN)) begin
                wr_a    = 1'b1;
                cnt_a_d = cnt_a_q + CW'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            CMD_APPEND_B: begin
              if (cnt_b_q < CW'(MAX_LEN)) begin
                wr_b    = 1'b1;
                cnt_b_d = cnt_b_q + CW'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            CMD_MERGE: begin
              if (total == '0) begin
                drop_d = 1'b0;
              end else begin
                state_d = ST_MERGE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MERGE: begin
        if (emit) begin
          out_valid_d = 1'b1;
          out_value_d = take_a ? head_a : head_b;
          out_last_d  = is_last;
          out_drop_d  = drop_q;
          if (take_a) begin
            idx_a_d = idx_a_q + CW'(1);
          end else begin
            idx_b_d = idx_b_q + CW'(1);
          end
          if (is_last) begin
            state_d = ST_IDLE;
            cnt_a_d = '0;
            cnt_b_d = '0;
            idx_a_d = '0;
            idx_b_d = '0;
            drop_d  = 1'b0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      idx_a_q     <= '0;
      idx_b_q     <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_a_q     <= cnt_a_d;
      cnt_b_q     <= cnt_b_d;
      idx_a_q     <= idx_a_d;
      idx_b_q     <= idx_b_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
    out_drop_q  <= out_drop_d;
  end

  // Read at the next index so the head is ready the cycle it is needed.
  slm_list_mem #(
    .DEPTH  (MAX_LEN),
    .ADDR_W (AW)
  ) u_list_a (
    .clk_i     (clk_i),
    .wr_en_i   (wr_a),
    .wr_addr_i (cnt_a_q[AW-1:0]),
    .wr_data_i (in_i.value),
    .rd_addr_i (idx_a_d[AW-1:0]),
    .rd_data_o (head_a)
  );

  slm_list_mem #(
    .DEPTH  (MAX_LEN),
    .ADDR_W (AW)
  ) u_list_b (
    .clk_i     (clk_i),
    .wr_en_i   (wr_b),
    .wr_addr_i (cnt_b_q[AW-1:0]),
    .wr_data_i (in_i.value),
    .rd_addr_i (idx_b_d[AW-1:0]),
    .rd_data_o (head_b)
  );

  assign out_o.valid        = out_valid_q;
  assign out_o.merged_value = out_value_q;
  assign out_o.last_item    = out_last_q;
  assign out_o.dropped      = out_drop_q;

`ifndef NO_ASSERTIONS
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE) |-> (idx_a_q <= cnt_a_q) && (idx_b_q <= cnt_b_q))
    else $error("merge index past list tail");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_a_q <= CW'(MAX_LEN)) && (cnt_b_q <= CW'(MAX_LEN)))
    else $error("list count exceeds capacity");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && is_last) |=> (cnt_a_q == '0) && (cnt_b_q == '0) && !drop_q
                          && (state_q == ST_IDLE))
    else $error("lists not emptied after final beat");

  a_merge_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE) |-> (total != '0) && (consumed <= total))
    else $error("merge running with no element left");
`endif

endmodule
